@@ hdl/rlcm_pkg.sv @@
// rlcm_pkg: shared types and constants for the running lcm / max ratio block
// used by rlcm_div, rlcm_datapath, rlcm_ctrl and running_lcm_and_max_ratio
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rlcm_pkg;

   // datapath widths
   localparam int ACC_BITS = 32;
   localparam int DIV_BITS = 32;
   localparam int MAX_BITS = 16;
   localparam int PROD_BITS = 2 * DIV_BITS;

   // saturation and clamp limits
   localparam logic [ACC_BITS-1:0] LCM_MAX = 32'h7FFF_FFFF;
   localparam logic signed [MAX_BITS-1:0] MAX_POS = 16'sh7FFF;
   localparam logic signed [ACC_BITS-1:0] MAX_POS_WIDE = 32'sh0000_7FFF;
   localparam logic signed [ACC_BITS-1:0] MIN_NEG_WIDE = -32'sh0000_8000;
   localparam logic signed [ACC_BITS-1:0] ROT_SINGLE = 32'sh0000_0001;

   // entries seen in the current list
   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE = 2'd1;
   localparam logic [1:0] SEEN_MANY = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_GCD_TEST,
      ST_GCD_DIV,
      ST_QUO_DIV,
      ST_MUL,
      ST_SETTLE,
      ST_END
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic fold;
      logic div_start;
      logic div_quo;
      logic gcd_step;
      logic mul;
      logic settle;
      logic finish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic simple;
      logic b_zero;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

@@ hdl/rlcm_div.sv @@
// rlcm_div: restoring divider, one quotient bit per cycle
// depends on rlcm_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlcm_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rlcm_pkg::DIV_BITS-1:0] dividend,
   input  wire logic [rlcm_pkg::DIV_BITS-1:0] divisor,
   output logic                               done,
   output logic [rlcm_pkg::DIV_BITS-1:0]      quotient,
   output logic [rlcm_pkg::DIV_BITS-1:0]      remainder
);

   localparam int W = rlcm_pkg::DIV_BITS;
   localparam int CW = $clog2(W);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic          fits;

   // one shift and trial subtract
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign fits = shifted >= {1'b0, dsr_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      count_in = count_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         count_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? W'(shifted - {1'b0, dsr_ff}) : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(W - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
   end

   // operand registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ hdl/rlcm_datapath.sv @@
// rlcm_datapath: list state, euclid registers, multiplier and result word
// depends on rlcm_pkg and rlcm_div
`timescale 1ns / 1ps
`default_nettype none

module rlcm_datapath #(
   parameter int RATIO_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire rlcm_pkg::cmd_type                    cmd,
   output rlcm_pkg::status_type                      status,
   input  wire logic signed [RATIO_BITS-1:0]         req_ratio,
   input  wire logic                                 req_last,
   output logic                                      rsp_strobe,
   output logic signed [rlcm_pkg::ACC_BITS-1:0]      rsp_rotations,
   output logic signed [rlcm_pkg::MAX_BITS-1:0]      rsp_max_ratio,
   output logic                                      rsp_overflow
);

   localparam int AB = rlcm_pkg::ACC_BITS;
   localparam int MB = rlcm_pkg::MAX_BITS;
   localparam int DB = rlcm_pkg::DIV_BITS;
   localparam int PB = rlcm_pkg::PROD_BITS;

   logic signed [RATIO_BITS-1:0] ratio_ff, ratio_in;
   logic                         last_ff, last_in;
   logic signed [AB-1:0]         acc_ff, acc_in;
   logic signed [MB-1:0]         max_work_ff, max_work_in;
   logic signed [MB-1:0]         max_held_ff, max_held_in;
   logic [1:0]                   seen_ff, seen_in;
   logic                         ovf_ff, ovf_in;
   logic [DB-1:0]                gcd_a_ff, gcd_a_in;
   logic [DB-1:0]                gcd_b_ff, gcd_b_in;
   logic [PB-1:0]                prod_ff, prod_in;
   logic                         strobe_ff, strobe_in;
   logic signed [AB-1:0]         rot_ff, rot_in;
   logic signed [MB-1:0]         mx_ff, mx_in;
   logic                         rovf_ff, rovf_in;

   logic signed [AB-1:0] r_ext;
   logic [DB-1:0]        r_abs;
   logic [DB-1:0]        acc_abs;
   logic signed [MB-1:0] seed_max;
   logic signed [MB-1:0] abs_max;
   logic [DB-1:0]        div_dividend;
   logic [DB-1:0]        div_divisor;
   logic                 div_done;
   logic [DB-1:0]        div_quo;
   logic [DB-1:0]        div_rem;

   // operand forms of the held ratio and the accumulator
   assign r_ext = {{(AB - RATIO_BITS){ratio_ff[RATIO_BITS-1]}}, ratio_ff};
   assign r_abs = r_ext[AB-1] ? DB'(-r_ext) : DB'(r_ext);
   assign acc_abs = acc_ff[AB-1] ? DB'(-acc_ff) : DB'(acc_ff);

   // signed seed clamped to 16 bits, magnitude saturated for the maximum
   always_comb begin
      if (r_ext > rlcm_pkg::MAX_POS_WIDE) begin
         seed_max = rlcm_pkg::MAX_POS;
      end else if (r_ext < rlcm_pkg::MIN_NEG_WIDE) begin
         seed_max = -rlcm_pkg::MAX_POS - 16'sd1;
      end else begin
         seed_max = r_ext[MB-1:0];
      end
      if (r_abs > DB'(rlcm_pkg::MAX_POS)) begin
         abs_max = rlcm_pkg::MAX_POS;
      end else begin
         abs_max = r_abs[MB-1:0];
      end
   end

   // cases that need no euclid run
   assign status.simple = (seen_ff == rlcm_pkg::SEEN_NONE) || (acc_ff == '0) ||
                          (ratio_ff == '0) || (acc_ff == r_ext);
   assign status.b_zero = (gcd_b_ff == '0);
   assign status.div_done = div_done;

   // divider operands: remainder step or final quotient |acc| / gcd
   assign div_dividend = cmd.div_quo ? acc_abs : gcd_a_ff;
   assign div_divisor = cmd.div_quo ? gcd_a_ff : gcd_b_ff;

   rlcm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // next values
   always_comb begin
      ratio_in = ratio_ff;
      last_in = last_ff;
      acc_in = acc_ff;
      max_work_in = max_work_ff;
      max_held_in = max_held_ff;
      seen_in = seen_ff;
      ovf_in = ovf_ff;
      gcd_a_in = gcd_a_ff;
      gcd_b_in = gcd_b_ff;
      prod_in = prod_ff;
      strobe_in = 1'b0;
      rot_in = rot_ff;
      mx_in = mx_ff;
      rovf_in = rovf_ff;

      // take the input word
      if (cmd.capture) begin
         ratio_in = req_ratio;
         last_in = req_last;
      end

      // seed, trivial fold, maximum and euclid setup
      if (cmd.fold) begin
         gcd_a_in = acc_abs;
         gcd_b_in = r_abs;
         if (seen_ff == rlcm_pkg::SEEN_NONE) begin
            acc_in = r_ext;
            max_work_in = seed_max;
            ovf_in = 1'b0;
            seen_in = rlcm_pkg::SEEN_ONE;
         end else begin
            if (abs_max > max_work_ff) begin
               max_work_in = abs_max;
            end
            seen_in = rlcm_pkg::SEEN_MANY;
            if (acc_ff == '0) begin
               acc_in = r_ext;
            end
         end
      end

      // one euclid remainder step
      if (cmd.gcd_step) begin
         gcd_a_in = gcd_b_ff;
         gcd_b_in = div_rem;
      end

      // (|acc| / gcd) * |ratio|
      if (cmd.mul) begin
         prod_in = PB'(div_quo) * PB'(r_abs);
      end

      // saturate the product into the accumulator
      if (cmd.settle) begin
         if (|prod_ff[PB-1:AB-1]) begin
            acc_in = signed'(rlcm_pkg::LCM_MAX);
            ovf_in = 1'b1;
         end else begin
            acc_in = signed'(prod_ff[AB-1:0]);
         end
      end

      // end of list: result word and list clear
      if (cmd.finish && last_ff) begin
         strobe_in = 1'b1;
         if (seen_ff == rlcm_pkg::SEEN_ONE) begin
            rot_in = rlcm_pkg::ROT_SINGLE;
            mx_in = max_held_ff;
            rovf_in = 1'b0;
         end else begin
            max_held_in = max_work_ff;
            rot_in = acc_ff;
            mx_in = max_work_ff;
            rovf_in = ovf_ff;
         end
         seen_in = rlcm_pkg::SEEN_NONE;
         ovf_in = 1'b0;
      end
   end

   // list state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         max_work_ff <= '0;
         max_held_ff <= '0;
         seen_ff <= rlcm_pkg::SEEN_NONE;
         ovf_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         max_work_ff <= max_work_in;
         max_held_ff <= max_held_in;
         seen_ff <= seen_in;
         ovf_ff <= ovf_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ratio_ff <= ratio_in;
      last_ff <= last_in;
      gcd_a_ff <= gcd_a_in;
      gcd_b_ff <= gcd_b_in;
      prod_ff <= prod_in;
      rot_ff <= rot_in;
      mx_ff <= mx_in;
      rovf_ff <= rovf_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_rotations = rot_ff;
   assign rsp_max_ratio = mx_ff;
   assign rsp_overflow = rovf_ff;

endmodule

`default_nettype wire

@@ hdl/rlcm_ctrl.sv @@
// rlcm_ctrl: sequencer for one word: fold, euclid loop, quotient, product
// depends on rlcm_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlcm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire rlcm_pkg::status_type status,
   output rlcm_pkg::cmd_type         cmd
);

   rlcm_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlcm_pkg::ST_IDLE: begin
            if (start) state_in = rlcm_pkg::ST_FOLD;
         end
         rlcm_pkg::ST_FOLD: begin
            state_in = status.simple ? rlcm_pkg::ST_END : rlcm_pkg::ST_GCD_TEST;
         end
         rlcm_pkg::ST_GCD_TEST: begin
            state_in = status.b_zero ? rlcm_pkg::ST_QUO_DIV : rlcm_pkg::ST_GCD_DIV;
         end
         rlcm_pkg::ST_GCD_DIV: begin
            if (status.div_done) state_in = rlcm_pkg::ST_GCD_TEST;
         end
         rlcm_pkg::ST_QUO_DIV: begin
            if (status.div_done) state_in = rlcm_pkg::ST_MUL;
         end
         rlcm_pkg::ST_MUL: begin
            state_in = rlcm_pkg::ST_SETTLE;
         end
         rlcm_pkg::ST_SETTLE: begin
            state_in = rlcm_pkg::ST_END;
         end
         rlcm_pkg::ST_END: begin
            state_in = rlcm_pkg::ST_IDLE;
         end
         default: begin
            state_in = rlcm_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         rlcm_pkg::ST_IDLE: begin
            busy = 1'b0;
            cmd.capture = start;
         end
         rlcm_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
         end
         rlcm_pkg::ST_GCD_TEST: begin
            cmd.div_start = 1'b1;
            cmd.div_quo = status.b_zero;
         end
         rlcm_pkg::ST_GCD_DIV: begin
            cmd.gcd_step = status.div_done;
         end
         rlcm_pkg::ST_QUO_DIV: begin
            cmd.mul = status.div_done;
         end
         rlcm_pkg::ST_MUL: begin
            cmd.settle = 1'b0;
         end
         rlcm_pkg::ST_SETTLE: begin
            cmd.settle = 1'b1;
         end
         rlcm_pkg::ST_END: begin
            cmd.finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlcm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/running_lcm_and_max_ratio.sv @@
// running_lcm_and_max_ratio: running lcm and maximum over lists of signed ratios
// first and trivial words skip the euclid loop; others run one divide per euclid
// remainder step and one for the quotient; a divide is start, 32 bit steps, done
// a word is taken only while idle; busy stays high until the word is folded in
// result word: one-cycle rsp_strobe after the last word; the receiver cannot stall
// synchronous active-high reset clears all list state and the held maximum
`timescale 1ns / 1ps
`default_nettype none

module running_lcm_and_max_ratio #(
   parameter int RATIO_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [RATIO_BITS-1:0]         req_ratio,
   input  wire logic                                 req_last,
   output logic                                      rsp_strobe,
   output logic signed [rlcm_pkg::ACC_BITS-1:0]      rsp_rotations,
   output logic signed [rlcm_pkg::MAX_BITS-1:0]      rsp_max_ratio,
   output logic                                      rsp_overflow
);

   rlcm_pkg::cmd_type    cmd;
   rlcm_pkg::status_type status;

   // sequencer
   rlcm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // arithmetic and list state
   rlcm_datapath #(
      .RATIO_BITS (RATIO_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_ratio     (req_ratio),
      .req_last      (req_last),
      .rsp_strobe    (rsp_strobe),
      .rsp_rotations (rsp_rotations),
      .rsp_max_ratio (rsp_max_ratio),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

`default_nettype wire

@@ sim/tb_running_lcm_and_max_ratio.sv @@
// tb_running_lcm_and_max_ratio: self-checking bench for the running lcm / max ratio block
// drives ratio lists through the start/busy port and compares each result word against
// a behavioral predictor or typed row; depends on rlcm_pkg and running_lcm_and_max_ratio
`timescale 1ns / 1ps

module tb_running_lcm_and_max_ratio;

   localparam int RATIO_W = 16;
   localparam int ACC_W = rlcm_pkg::ACC_BITS;
   localparam int MAX_W = rlcm_pkg::MAX_BITS;
   localparam int RANDOM_WORDS = 800;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int TAIL_CYCLES = 2000;

   typedef struct packed {
      logic signed [ACC_W-1:0] rotations;
      logic signed [MAX_W-1:0] max_ratio;
      logic                    overflow;
   } lcm_result_type;

   typedef struct packed {
      logic signed [RATIO_W-1:0] ratio;
      logic                      last;
      logic                      drain;
      logic                      typed;
      lcm_result_type            want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [RATIO_W-1:0] req_ratio = '0;
   logic req_last = 1'b0;
   logic rsp_strobe;
   logic signed [ACC_W-1:0] rsp_rotations;
   logic signed [MAX_W-1:0] rsp_max_ratio;
   logic rsp_overflow;

   // typed-in expectation travelling with the word being offered
   logic word_typed = 1'b0;
   lcm_result_type word_want = '0;

   // predictor state
   logic signed [ACC_W-1:0] lcm_run = '0;
   logic signed [MAX_W-1:0] max_run = '0;
   logic signed [MAX_W-1:0] max_prev = '0;
   logic [1:0] seen = rlcm_pkg::SEEN_NONE;
   logic ovf_run = 1'b0;

   lcm_result_type pending_results[$];
   stim_row_type stim_rows[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int words_sent = 0;
   bit no_gaps = 1'b0;

   running_lcm_and_max_ratio #(
      .RATIO_BITS(RATIO_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_ratio(req_ratio),
      .req_last(req_last),
      .rsp_strobe(rsp_strobe),
      .rsp_rotations(rsp_rotations),
      .rsp_max_ratio(rsp_max_ratio),
      .rsp_overflow(rsp_overflow)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic longint unsigned gcd_of(input longint unsigned x,
                                              input longint unsigned y);
      longint unsigned a;
      longint unsigned b;
      longint unsigned t;
      a = x;
      b = y;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // one lcm fold step; sat flags a product above the positive range
   function automatic logic signed [ACC_W-1:0] lcm_of(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [RATIO_W-1:0] b,
                                                      output bit sat);
      logic signed [ACC_W-1:0] bw;
      logic signed [ACC_W-1:0] folded;
      longint sa;
      longint sb;
      longint unsigned ua;
      longint unsigned ub;
      longint unsigned g;
      longint unsigned prod;
      sat = 1'b0;
      bw = ACC_W'(b);
      sa = longint'(a);
      sb = longint'(b);
      if (a == 0) begin
         folded = bw;
      end else if (b == 0) begin
         folded = a;
      end else if (a == bw) begin
         folded = a;
      end else begin
         ua = (sa < 0) ? -sa : sa;
         ub = (sb < 0) ? -sb : sb;
         g = gcd_of(ua, ub);
         if (g == 0) g = 1;
         prod = (ua / g) * ub;
         if (prod > {32'd0, rlcm_pkg::LCM_MAX}) begin
            sat = 1'b1;
            folded = rlcm_pkg::LCM_MAX;
         end else begin
            folded = prod[ACC_W-1:0];
         end
      end
      return folded;
   endfunction

   // fold one accepted word into the predictor; emits on the last word of a list
   task automatic predict_word(input logic signed [RATIO_W-1:0] ratio, input logic last_w,
                               output bit emits, output lcm_result_type res);
      logic signed [MAX_W-1:0] mag;
      bit sat;
      emits = 1'b0;
      res = '0;
      if (seen == rlcm_pkg::SEEN_NONE) begin
         lcm_run = ACC_W'(ratio);
         max_run = ratio;
         ovf_run = 1'b0;
         seen = rlcm_pkg::SEEN_ONE;
      end else begin
         // most negative code saturates for the maximum only
         if (ratio == -16'sd32768) mag = rlcm_pkg::MAX_POS;
         else if (ratio < 0) mag = -ratio;
         else mag = ratio;
         lcm_run = lcm_of(lcm_run, ratio, sat);
         if (sat) ovf_run = 1'b1;
         if (mag > max_run) max_run = mag;
         seen = rlcm_pkg::SEEN_MANY;
      end
      if (last_w) begin
         emits = 1'b1;
         if (seen == rlcm_pkg::SEEN_ONE) begin
            res.rotations = rlcm_pkg::ROT_SINGLE;
            res.max_ratio = max_prev;
            res.overflow = 1'b0;
         end else begin
            max_prev = max_run;
            res.rotations = lcm_run;
            res.max_ratio = max_prev;
            res.overflow = ovf_run;
         end
         seen = rlcm_pkg::SEEN_NONE;
         ovf_run = 1'b0;
      end
   endtask

   // result check first, then prediction of the word accepted at this edge
   always @(posedge clock) begin
      bit emits;
      lcm_result_type res;
      lcm_result_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected: %0d %0d %0d",
                                         rsp_rotations, rsp_max_ratio, rsp_overflow));
            end else begin
               want = pending_results.pop_front();
               if (rsp_rotations !== want.rotations)
                  report_mismatch($sformatf("rotations got %0d want %0d",
                                            rsp_rotations, want.rotations));
               if (rsp_max_ratio !== want.max_ratio)
                  report_mismatch($sformatf("max_ratio got %0d want %0d",
                                            rsp_max_ratio, want.max_ratio));
               if (rsp_overflow !== want.overflow)
                  report_mismatch($sformatf("overflow got %0b want %0b",
                                            rsp_overflow, want.overflow));
            end
         end
         if (start && busy === 1'b0) begin
            predict_word(req_ratio, req_last, emits, res);
            if (emits) begin
               if (word_typed) pending_results.push_back(word_want);
               else pending_results.push_back(res);
            end
         end
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // offer one word, hold it until accepted, then idle for a random gap, which may be empty
   task automatic send_word(input logic signed [RATIO_W-1:0] ratio, input logic last_w,
                            input logic typed, input lcm_result_type want);
      int gap;
      req_ratio = ratio;
      req_last = last_w;
      word_typed = typed;
      word_want = want;
      start = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      words_sent++;
      @(negedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input logic signed [RATIO_W-1:0] ratio, input logic last_w,
                          input logic drain, input logic typed,
                          input logic signed [ACC_W-1:0] rot,
                          input logic signed [MAX_W-1:0] mx, input logic ovf);
      stim_row_type row;
      row.ratio = ratio;
      row.last = last_w;
      row.drain = drain;
      row.typed = typed;
      row.want.rotations = rot;
      row.want.max_ratio = mx;
      row.want.overflow = ovf;
      stim_rows.push_back(row);
   endtask

   function automatic logic signed [RATIO_W-1:0] rand_ratio(
         input logic signed [RATIO_W-1:0] prev);
      int sel;
      logic signed [RATIO_W-1:0] v;
      sel = $urandom_range(0, 99);
      if (sel < 40) v = RATIO_W'($urandom_range(1, 12));
      else if (sel < 55) v = RATIO_W'($urandom_range(1, 255));
      else if (sel < 75) return RATIO_W'($urandom);
      else if (sel < 82) return '0;
      else if (sel < 88) begin
         case ($urandom_range(0, 4))
            0: return 16'sd32767;
            1: return -16'sd32767;
            2: return -16'sd32768;
            3: return 16'sd1;
            default: return -16'sd1;
         endcase
      end else if (sel < 94) return prev;
      else v = 16'sd1 <<< $urandom_range(0, 14);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   initial begin
      stim_row_type row;
      lcm_result_type none;
      logic signed [RATIO_W-1:0] prev;
      int len;
      int list_idx;
      none = '0;
      prev = '0;

      // directed lists: single word after reset, zero operand, equal operands,
      // held maximum, saturation with the most negative code, folding after saturation
      add_row(16'sd5, 1'b1, 1'b0, 1'b1, 32'sd1, 16'sd0, 1'b0);
      add_row(16'sd0, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(16'sd7, 1'b1, 1'b0, 1'b1, 32'sd7, 16'sd7, 1'b0);
      add_row(-16'sd6, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(16'sd4, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(-16'sd5, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(-16'sd5, 1'b1, 1'b0, 1'b1, -32'sd5, 16'sd5, 1'b0);
      add_row(-16'sd3, 1'b1, 1'b0, 1'b1, 32'sd1, 16'sd5, 1'b0);
      add_row(16'sd32767, 1'b0, 1'b1, 1'b0, 0, 0, 1'b0);
      add_row(16'sd32766, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(-16'sd32768, 1'b1, 1'b0, 1'b1, rlcm_pkg::LCM_MAX, rlcm_pkg::MAX_POS, 1'b1);
      add_row(-16'sd32768, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(-16'sd32768, 1'b1, 1'b0, 1'b1, -32'sd32768, rlcm_pkg::MAX_POS, 1'b0);
      add_row(16'sd30000, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(16'sd29999, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(16'sd29998, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(16'sd1, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(-16'sd4, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(16'sd0, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(16'sd0, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(16'sd0, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(16'sd2, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(-16'sd3, 1'b0, 1'b0, 1'b0, 0, 0, 1'b0);
      add_row(16'sd4, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);

      // hold reset, then release it on a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      while (stim_rows.size() != 0) begin
         row = stim_rows.pop_front();
         if (row.drain) wait_drained();
         send_word(row.ratio, row.last, row.typed, row.want);
      end

      // random lists, with stretches of back-to-back words and occasional drains
      words_sent = 0;
      list_idx = 0;
      while (words_sent < RANDOM_WORDS) begin
         no_gaps = ((list_idx / 12) % 4) == 1;
         if ($urandom_range(0, 19) == 0) wait_drained();
         case ($urandom_range(0, 19))
            0, 1, 2: len = 1;
            3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: len = $urandom_range(2, 4);
            default: len = $urandom_range(5, 8);
         endcase
         for (int i = 0; i < len; i++) begin
            prev = rand_ratio(prev);
            send_word(prev, i == len - 1, 1'b0, none);
         end
         list_idx++;
      end

      // drain and let the block settle
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
